// ===== rtl/core/radix_page_table_walker_assert.svh =====
// Assertion macros used by the page table walker controller.
`ifndef RADIX_PAGE_TABLE_WALKER_ASSERT_SVH
`define RADIX_PAGE_TABLE_WALKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPTW_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: consequent in same cycle");

// The consequent must hold in the cycle after the antecedent.
`define RPTW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: consequent in next cycle");

`endif

// ===== rtl/core/rptw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rptw_pkg;

    localparam int TABLE_COUNT       = 8;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int TBL_W             = $clog2(TABLE_COUNT);
    localparam int ENTRY_W           = $clog2(ENTRIES_PER_TABLE);
    localparam int ADDR_W            = TBL_W + ENTRY_W;
    localparam int STORE_DEPTH       = TABLE_COUNT * ENTRIES_PER_TABLE;

    localparam int WORD_W   = 64;
    localparam int VA_W     = 57;
    localparam int PA_W     = 52;
    localparam int FRAME_W  = 40;
    localparam int LEVEL_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] ACT_WRITE     = 2'd0;
    localparam logic [1:0] ACT_TRANSLATE = 2'd1;
    localparam logic [1:0] ACT_UNMAP     = 2'd2;

    localparam logic [1:0] SIZE_NONE = 2'd0;
    localparam logic [1:0] SIZE_4K   = 2'd1;
    localparam logic [1:0] SIZE_2M   = 2'd2;
    localparam logic [1:0] SIZE_1G   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIVE_LEVEL = 2'd1;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP4 = 3'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP5 = 3'd5;

    localparam logic [PA_W-1:0]   MASK_1G   = 52'hF_FFFF_C000_0000;
    localparam logic [PA_W-1:0]   MASK_2M   = 52'hF_FFFF_FFE0_0000;
    localparam logic [PA_W-1:0]   MASK_4K   = 52'hF_FFFF_FFFF_F000;
    localparam logic [WORD_W-1:0] FLAG_MASK = 64'h8000_0000_0000_0FFF;
    localparam int PRESENT_BIT = 0;
    localparam int PS_BIT      = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_START,
        ST_WALK,
        ST_CLEAR,
        ST_DONE
    } rptw_state_t;

    typedef struct packed {
        logic load;
        logic wr_item;
        logic wr_clear;
        logic rd_start;
        logic rd_descend;
        logic rec_leaf;
        logic set_fault;
        logic out_load;
    } rptw_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       root_fault;
        logic       present;
        logic       last;
        logic       ps_leaf;
        logic       next_fault;
    } rptw_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/radix_page_table_walker.sv =====
// Channel   Handshake              Payload
// s_        s_valid / s_ready      action, table_number, entry_index, entry_value,
//                                  virtual_address
// m_        m_valid / m_ready      present, leaf_size, leaf_base, leaf_flags,
//                                  table_fault
// cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// One item is in flight at a time. A walk reads one table entry per cycle from
// the single-port-read table store, reading up to five levels from the top down,
// and an unmap then clears the leaf entry in a further step.
// The table store is not cleared by reset; only control and configuration are.
// A result waits in the output register while m_ready is low; the next item
// finishes its walk but holds until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module radix_page_table_walker
    import rptw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_action,
    input  wire logic [2:0]            s_table_number,
    input  wire logic [8:0]            s_entry_index,
    input  wire logic [WORD_W-1:0]     s_entry_value,
    input  wire logic [VA_W-1:0]       s_virtual_address,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_present,
    output logic [1:0]                 m_leaf_size,
    output logic [PA_W-1:0]            m_leaf_base,
    output logic [WORD_W-1:0]          m_leaf_flags,
    output logic                       m_table_fault
);

    rptw_cmd_t    cmd;
    rptw_status_t status;

    assign cfg_ready = 1'b1;

    rptw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rptw_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_action          (s_action),
        .s_table_number    (s_table_number),
        .s_entry_index     (s_entry_index),
        .s_entry_value     (s_entry_value),
        .s_virtual_address (s_virtual_address),
        .cmd               (cmd),
        .in_idle           (s_ready),
        .status            (status),
        .m_present         (m_present),
        .m_leaf_size       (m_leaf_size),
        .m_leaf_base       (m_leaf_base),
        .m_leaf_flags      (m_leaf_flags),
        .m_table_fault     (m_table_fault)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rptw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rptw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "radix_page_table_walker_assert.svh"

module rptw_ctrl
    import rptw_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire rptw_status_t status,
    output rptw_cmd_t         cmd
);

    rptw_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;
    logic        leaf_hit;

    assign out_free = !m_valid_reg || m_ready;
    // At level 1 a present entry is the leaf; at levels 2 and 3 only a present PS entry is.
    assign leaf_hit = status.last ? status.present : (status.present && status.ps_leaf);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (status.action)
                        ACT_WRITE:                  state_next = ST_WRITE;
                        ACT_TRANSLATE, ACT_UNMAP:   state_next = ST_START;
                        default:                    state_next = ST_DONE;
                    endcase
                end
            end
            ST_WRITE: state_next = ST_DONE;
            ST_START: state_next = status.root_fault ? ST_DONE : ST_WALK;
            ST_WALK: begin
                if (status.last || (status.present && status.ps_leaf)) begin
                    state_next = (status.action == ACT_UNMAP) ? ST_CLEAR : ST_DONE;
                end else if (!status.present || status.next_fault) begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_WRITE: cmd.wr_item = 1'b1;
            ST_START: begin
                cmd.set_fault = status.root_fault;
                cmd.rd_start  = !status.root_fault;
            end
            ST_WALK: begin
                cmd.rec_leaf = leaf_hit;
                if (!status.last && status.present && !status.ps_leaf) begin
                    cmd.set_fault  = status.next_fault;
                    cmd.rd_descend = !status.next_fault;
                end
            end
            ST_CLEAR: cmd.wr_clear = 1'b1;
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;

    `RPTW_ASSERT_SAME(a_out_load_free, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready)
    `RPTW_ASSERT_SAME(a_clear_only_unmap, aclk, aresetn, cmd.wr_clear,
                      status.action == ACT_UNMAP)
    `RPTW_ASSERT_SAME(a_no_descend_at_leaf, aclk, aresetn, status.last && state_reg == ST_WALK,
                      !cmd.rd_descend)
    `RPTW_ASSERT_NEXT(a_one_item_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

`default_nettype wire

// ===== rtl/core/rptw_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rptw_dp
    import rptw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [1:0]            s_action,
    input  wire logic [2:0]            s_table_number,
    input  wire logic [8:0]            s_entry_index,
    input  wire logic [WORD_W-1:0]     s_entry_value,
    input  wire logic [VA_W-1:0]       s_virtual_address,
    input  wire rptw_cmd_t             cmd,
    input  wire logic                  in_idle,
    output rptw_status_t               status,
    output logic                       m_present,
    output logic [1:0]                 m_leaf_size,
    output logic [PA_W-1:0]            m_leaf_base,
    output logic [WORD_W-1:0]          m_leaf_flags,
    output logic                       m_table_fault
);

    logic [2:0]         root_reg;
    logic               five_level_reg;
    logic [1:0]         action_reg;
    logic [2:0]         tn_reg;
    logic [8:0]         ei_reg;
    logic [WORD_W-1:0]  ev_reg;
    logic [VA_W-1:0]    va_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [ADDR_W-1:0]  addr_reg;

    logic               res_present;
    logic [1:0]         res_size;
    logic [PA_W-1:0]    res_base;
    logic [WORD_W-1:0]  res_flags;
    logic               res_fault;

    logic [WORD_W-1:0]  rdata;
    logic [FRAME_W-1:0] frame;
    logic [LEVEL_W-1:0] rd_level;
    logic [TBL_W-1:0]   rd_table;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;
    logic               wr_ok;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [WORD_W-1:0]  wdata;

    function automatic logic [ENTRY_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                    input logic [LEVEL_W-1:0] lvl);
        logic [ENTRY_W-1:0] idx;
        case (lvl)
            3'd1:    idx = va[20:12];
            3'd2:    idx = va[29:21];
            3'd3:    idx = va[38:30];
            3'd4:    idx = va[47:39];
            3'd5:    idx = va[56:48];
            default: idx = '0;
        endcase
        return idx;
    endfunction

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg       <= '0;
            five_level_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ROOT_TABLE: root_reg       <= cfg_data[2:0];
                CFG_FIVE_LEVEL: five_level_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign frame    = rdata[12 +: FRAME_W];
    assign rd_level = cmd.rd_descend ? LEVEL_W'(level_reg - 3'd1) : level_reg;
    assign rd_table = cmd.rd_descend ? TBL_W'(frame) : TBL_W'(root_reg);
    assign rd_addr  = {rd_table, va_index(va_reg, rd_level)};
    assign rd_en    = cmd.rd_start || cmd.rd_descend;

    assign wr_ok = 32'(tn_reg) < TABLE_COUNT;
    assign we    = (cmd.wr_item && wr_ok) || cmd.wr_clear;
    assign waddr = cmd.wr_clear ? addr_reg : {TBL_W'(tn_reg), ei_reg};
    assign wdata = cmd.wr_clear ? '0 : ev_reg;

    rptw_ram #(
        .WIDTH(WORD_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_action;
            tn_reg     <= s_table_number;
            ei_reg     <= s_entry_index;
            ev_reg     <= s_entry_value;
            va_reg     <= s_virtual_address;
            level_reg  <= five_level_reg ? LEVEL_TOP5 : LEVEL_TOP4;
        end else if (cmd.rd_descend) begin
            level_reg <= rd_level;
        end
        if (rd_en) begin
            addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_present <= 1'b0;
            res_size    <= SIZE_NONE;
            res_base    <= '0;
            res_flags   <= '0;
            res_fault   <= 1'b0;
        end else begin
            if (cmd.rec_leaf) begin
                res_present <= 1'b1;
                res_flags   <= rdata & FLAG_MASK;
                case (level_reg)
                    3'd3: begin
                        res_size <= SIZE_1G;
                        res_base <= rdata[PA_W-1:0] & MASK_1G;
                    end
                    3'd2: begin
                        res_size <= SIZE_2M;
                        res_base <= rdata[PA_W-1:0] & MASK_2M;
                    end
                    default: begin
                        res_size <= SIZE_4K;
                        res_base <= rdata[PA_W-1:0] & MASK_4K;
                    end
                endcase
            end
            if (cmd.set_fault) begin
                res_fault <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_present     <= res_present;
            m_leaf_size   <= res_size;
            m_leaf_base   <= res_base;
            m_leaf_flags  <= res_flags;
            m_table_fault <= res_fault;
        end
    end

    // While idle the controller decodes the offered action directly.
    always_comb begin
        status            = '0;
        status.action     = in_idle ? s_action : action_reg;
        status.root_fault = 32'(root_reg) >= TABLE_COUNT;
        status.present    = rdata[PRESENT_BIT];
        status.last       = level_reg == 3'd1;
        status.ps_leaf    = rdata[PS_BIT] && (level_reg == 3'd3 || level_reg == 3'd2);
        status.next_fault = frame >= FRAME_W'(TABLE_COUNT);
    end

endmodule

`default_nettype wire
